[rtl/otws_pkg.sv]
package otws_pkg;

  // Operation codes of a request
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_READ     = 3'd2;
  localparam logic [2:0] OP_FIND     = 3'd3;
  localparam logic [2:0] OP_POSITION = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Result update selected by the controller
  typedef logic [3:0] res_code_t;

  localparam res_code_t RES_NONE  = 4'd0;
  localparam res_code_t RES_ZERO  = 4'd1;
  localparam res_code_t RES_RANGE = 4'd2;
  localparam res_code_t RES_FULL  = 4'd3;
  localparam res_code_t RES_INS   = 4'd4;
  localparam res_code_t RES_REM   = 4'd5;
  localparam res_code_t RES_READ  = 4'd6;
  localparam res_code_t RES_HIT   = 4'd7;
  localparam res_code_t RES_MISS  = 4'd8;
  localparam res_code_t RES_LO    = 4'd9;

  typedef struct packed {
    logic      load;
    logic      rd;
    logic      shift;
    logic      bs_rd;
    logic      bs_step;
    logic      tail;
    res_code_t res;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sorted;
    logic       run_zero;
    logic       ins_full;
    logic       rem_bad;
    logic       read_bad;
    logic       more;
    logic       rd_vld;
    logic       hit;
    logic       bs_open;
    logic       lo_zero;
  } sts_t;

endpackage

[rtl/ordered_table_with_search.sv]
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------------
// in_      | in_valid / in_stall   | opcode, slot, run_length, value
// out_     | out_valid / out_stall | status, found, position, read_value, occupancy
// cfg_     | cfg_valid / cfg_ready | sorted_mode
//
// One request at a time: a new one is taken only once the last result has been pushed.
// Insert and remove move the shifted entries one by one, a read fetches one entry, a linear
// find scans in order, and a sorted position or find runs a binary search (find checks one more).
// The entry store gives one read and one write per cycle.
// Synchronous active-low reset clears the count, the mode and all control; entries hold none.
// A result waits in the output register while the next request is taken; a stalled one holds.
module ordered_table_with_search #(
  parameter int DEPTH      = 64,
  parameter int ENTRY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_slot,
  input  logic [6:0]  in_run_length,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [6:0]  out_position,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_occupancy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_sorted_mode
);
  import otws_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cmd_t                  cmd;
  sts_t                  sts;
  logic                  push;
  logic                  out_free;
  logic [1:0]            res_status;
  logic                  res_found;
  logic [CW-1:0]         res_pos;
  logic [ENTRY_BITS-1:0] res_rd;
  logic [CW-1:0]         count;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic                  out_found_r;
  logic [6:0]            out_position_r;
  logic [31:0]           out_read_value_r;
  logic [6:0]            out_occupancy_r;

  // Configuration is to be written only while idle (the block does not enforce it), so take it at once
  assign cfg_ready = 1'b1;

  // Output slot is free when empty or being emptied this cycle
  assign out_free = !out_valid_r || !out_stall;

  otws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall),
    .push     (push)
  );

  otws_dp #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_slot         (in_slot),
    .in_run_length   (in_run_length),
    .in_value        (in_value),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_sorted_mode (cfg_sorted_mode),
    .sts             (sts),
    .res_status      (res_status),
    .res_found       (res_found),
    .res_pos         (res_pos),
    .res_rd          (res_rd),
    .count           (count)
  );

  // Hold the valid flag; set it on a push, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload on a push; hold it otherwise
  always_ff @(posedge clk) begin
    if (push) begin
      out_status_r     <= res_status;
      out_found_r      <= res_found;
      out_position_r   <= 7'(res_pos);
      out_read_value_r <= 32'(res_rd);
      out_occupancy_r  <= 7'(count);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_position   = out_position_r;
  assign out_read_value = out_read_value_r;
  assign out_occupancy  = out_occupancy_r;

  // The count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(DEPTH))
    else $error("entry count exceeds table size");

  // An accepted request makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block not busy");

  // While idle the count does not move
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> $stable(count))
    else $error("entry count changed while idle");

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !push)
    else $error("result pushed over a stalled result");

endmodule

[rtl/otws_ctrl.sv]
module otws_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  input  otws_pkg::sts_t  sts,
  output otws_pkg::cmd_t  cmd,
  output logic            in_stall,
  output logic            push
);
  import otws_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SHIFT  = 4'd2;
  localparam logic [3:0] S_KEY    = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_BS_RD  = 4'd6;
  localparam logic [3:0] S_BS_CMP = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    push      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (sts.op)
          OP_INSERT: begin
            if (sts.run_zero) begin
              cmd.res = RES_ZERO;
            end else if (sts.ins_full) begin
              cmd.res = RES_FULL;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          OP_REMOVE: begin
            if (sts.run_zero) begin
              cmd.res = RES_ZERO;
            end else if (sts.rem_bad) begin
              cmd.res = RES_RANGE;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          OP_READ: begin
            if (sts.read_bad) begin
              cmd.res = RES_RANGE;
            end else begin
              state_nxt = S_READ;
            end
          end
          OP_FIND: begin
            state_nxt = sts.sorted ? S_BS_RD : S_SCAN;
          end
          OP_POSITION: begin
            if (sts.sorted) begin
              state_nxt = S_BS_RD;
            end else begin
              cmd.res = RES_MISS;
            end
          end
          default: begin
            cmd.res = RES_ZERO;
          end
        endcase
      end
      S_SHIFT: begin
        // stream entries through the read port, writing each one back in the following cycle
        cmd.shift = 1'b1;
        cmd.rd    = sts.more;
        if (!sts.more && !sts.rd_vld) begin
          if (sts.op == OP_INSERT) begin
            state_nxt = S_KEY;
          end else begin
            cmd.res   = RES_REM;
            state_nxt = S_DONE;
          end
        end
      end
      S_KEY: begin
        cmd.res   = RES_INS;
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd = sts.more;
        if (sts.rd_vld) begin
          cmd.res   = RES_READ;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.res   = RES_HIT;
          state_nxt = S_DONE;
        end else if (!sts.more && !sts.rd_vld) begin
          cmd.res   = RES_MISS;
          state_nxt = S_DONE;
        end else begin
          cmd.rd = sts.more;
        end
      end
      S_BS_RD: begin
        if (sts.bs_open) begin
          cmd.bs_rd = 1'b1;
          state_nxt = S_BS_CMP;
        end else if (sts.op == OP_FIND) begin
          if (sts.lo_zero) begin
            cmd.res   = RES_MISS;
            state_nxt = S_DONE;
          end else begin
            // check the entry just below the upper bound
            cmd.tail  = 1'b1;
            state_nxt = S_SCAN;
          end
        end else begin
          cmd.res   = RES_LO;
          state_nxt = S_DONE;
        end
      end
      S_BS_CMP: begin
        cmd.bs_step = 1'b1;
        state_nxt   = S_BS_RD;
      end
      S_DONE: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/otws_dp.sv]
module otws_dp #(
  parameter int DEPTH      = 64,
  parameter int ENTRY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  otws_pkg::cmd_t                cmd,
  input  logic [2:0]                    in_opcode,
  input  logic [7:0]                    in_slot,
  input  logic [6:0]                    in_run_length,
  input  logic [31:0]                   in_value,
  input  logic                          cfg_we,
  input  logic                          cfg_sorted_mode,
  output otws_pkg::sts_t                sts,
  output logic [1:0]                    res_status,
  output logic                          res_found,
  output logic [$clog2(DEPTH+1)-1:0]    res_pos,
  output logic [ENTRY_BITS-1:0]         res_rd,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import otws_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int AW = ((CW > 8) ? CW : 8) + 1;

  logic [ENTRY_BITS-1:0] mem_r [DEPTH];

  logic                  sorted_r;
  logic [2:0]            op_r;
  logic [7:0]            slot_r;
  logic [6:0]            run_r;
  logic [ENTRY_BITS-1:0] key_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [IW-1:0]         ptr_r;
  logic [CW-1:0]         rem_r;
  logic [CW-1:0]         lo_r;
  logic [CW-1:0]         hi_r;
  logic [IW-1:0]         rtag_r;
  logic                  rvld_r;
  logic [ENTRY_BITS-1:0] rdata_r;

  logic [1:0]            res_status_r, res_status_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [CW-1:0]         res_pos_r, res_pos_nxt;
  logic [ENTRY_BITS-1:0] res_rd_r, res_rd_nxt;

  logic [AW-1:0]         cnt_w, slot_w, run_w, idx_w, ld_slot_w, ld_run_w, ld_idx_w;
  logic [IW-1:0]         mid;
  logic                  rd_fire;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;

  assign cnt_w     = AW'(count_r);
  assign slot_w    = AW'(slot_r);
  assign run_w     = AW'(run_r);
  assign idx_w     = (slot_w < cnt_w) ? slot_w : cnt_w;
  assign ld_slot_w = AW'(in_slot);
  assign ld_run_w  = AW'(in_run_length);
  assign ld_idx_w  = (ld_slot_w < cnt_w) ? ld_slot_w : cnt_w;
  assign mid       = IW'((AW'(lo_r) + AW'(hi_r)) >> 1);

  assign sts.op       = op_r;
  assign sts.sorted   = sorted_r;
  assign sts.run_zero = (run_r == '0);
  assign sts.ins_full = (count_r == CW'(DEPTH));
  assign sts.rem_bad  = (slot_w >= cnt_w) || ((slot_w + run_w) > cnt_w);
  assign sts.read_bad = (slot_w >= cnt_w);
  assign sts.more     = (rem_r != '0);
  assign sts.rd_vld   = rvld_r;
  assign sts.hit      = rvld_r && (rdata_r == key_r);
  assign sts.bs_open  = (lo_r < hi_r);
  assign sts.lo_zero  = (lo_r == '0);

  // Single read port and single write port on the entry store
  assign rd_fire = cmd.rd || cmd.bs_rd;
  assign rd_addr = cmd.bs_rd ? mid : ptr_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rtag_r;
    wr_data = rdata_r;
    if (cmd.res == RES_INS) begin
      wr_en   = 1'b1;
      wr_addr = IW'(idx_w);
      wr_data = key_r;
    end else if (cmd.shift && rvld_r) begin
      wr_en = 1'b1;
      if (op_r == OP_INSERT) begin
        wr_addr = IW'(AW'(rtag_r) + AW'(1));
      end else begin
        wr_addr = IW'(AW'(rtag_r) - run_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      rdata_r <= mem_r[rd_addr];
    end
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    res_rd_nxt     = res_rd_r;
    if (cmd.res != RES_NONE) begin
      res_status_nxt = ST_OK;
      res_found_nxt  = 1'b0;
      res_pos_nxt    = '0;
      res_rd_nxt     = '0;
    end
    case (cmd.res)
      RES_RANGE: res_status_nxt = ST_RANGE;
      RES_FULL:  res_status_nxt = ST_FULL;
      RES_INS: begin
        res_pos_nxt = CW'(idx_w);
        count_nxt   = CW'(cnt_w + AW'(1));
      end
      RES_REM: begin
        res_pos_nxt = CW'(slot_w);
        count_nxt   = CW'(cnt_w - run_w);
      end
      RES_READ: begin
        res_pos_nxt = CW'(rtag_r);
        res_rd_nxt  = rdata_r;
      end
      RES_HIT: begin
        res_found_nxt = 1'b1;
        res_pos_nxt   = CW'(rtag_r);
      end
      RES_MISS: res_pos_nxt = count_r;
      RES_LO:   res_pos_nxt = lo_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sorted_r <= 1'b0;
      rvld_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rvld_r  <= rd_fire;
      if (cfg_we) begin
        sorted_r <= cfg_sorted_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_pos_r    <= res_pos_nxt;
    res_rd_r     <= res_rd_nxt;
    if (rd_fire) begin
      rtag_r <= rd_addr;
    end
    if (cmd.load) begin
      op_r   <= in_opcode;
      slot_r <= in_slot;
      run_r  <= in_run_length;
      key_r  <= ENTRY_BITS'(in_value);
      lo_r   <= '0;
      hi_r   <= count_r;
      case (in_opcode)
        OP_INSERT: begin
          ptr_r <= IW'(cnt_w - AW'(1));
          rem_r <= CW'(cnt_w - ld_idx_w);
        end
        OP_REMOVE: begin
          ptr_r <= IW'(ld_slot_w + ld_run_w);
          rem_r <= CW'(cnt_w - ld_slot_w - ld_run_w);
        end
        OP_READ: begin
          ptr_r <= IW'(ld_slot_w);
          rem_r <= CW'(1);
        end
        default: begin
          ptr_r <= '0;
          rem_r <= count_r;
        end
      endcase
    end else if (cmd.tail) begin
      ptr_r <= IW'(lo_r - CW'(1));
      rem_r <= CW'(1);
    end else if (cmd.rd) begin
      // walk down for insert, up for everything else
      ptr_r <= (op_r == OP_INSERT) ? (ptr_r - IW'(1)) : (ptr_r + IW'(1));
      rem_r <= rem_r - CW'(1);
    end
    if (cmd.bs_step) begin
      if (key_r >= rdata_r) begin
        lo_r <= CW'(rtag_r) + CW'(1);
      end else begin
        hi_r <= CW'(rtag_r);
      end
    end
  end

  assign res_status = res_status_r;
  assign res_found  = res_found_r;
  assign res_pos    = res_pos_r;
  assign res_rd     = res_rd_r;
  assign count      = count_r;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import otws_pkg::*;

  localparam int DEPTH          = 64;
  localparam int PHASE_REQUESTS = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  // Longest request is a linear find or shift over a full table.
  localparam int SETTLE_CYCLES  = 100;
  // Mode of each random phase, lowest bit first: sorted, plain, sorted, plain.
  localparam logic [3:0] PHASE_MODES = 4'b0101;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  slot;
    logic [6:0]  run_length;
    logic [31:0] value;
  } op_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [6:0]  position;
    logic [31:0] read_value;
    logic [6:0]  occupancy;
  } op_result_t;

  // One line of the directed stimulus: the mode it runs in, the request, and
  // where the answer is obvious, the result typed in by hand.
  typedef struct {
    logic       sorted;
    op_req_t    req;
    bit         typed;
    op_result_t want;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic [7:0]  in_slot;
  logic [6:0]  in_run_length;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_found;
  logic [6:0]  out_position;
  logic [31:0] out_read_value;
  logic [6:0]  out_occupancy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_sorted_mode;

  // Shadow copy of the table, its count and the search mode.
  logic [31:0] shadow_entries [DEPTH];
  int          shadow_count;
  logic        shadow_sorted;

  op_result_t  pending_results [$];
  step_row_t   directed_rows [$];

  int  mismatches;
  int  requests_sent;
  int  sorted_requests;
  int  results_seen;
  int  full_seen;
  int  range_seen;
  int  stuck_cycles;
  bit  no_idling;

  ordered_table_with_search u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_slot         (in_slot),
    .in_run_length   (in_run_length),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_read_value  (out_read_value),
    .out_occupancy   (out_occupancy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_sorted_mode (cfg_sorted_mode)
  );

  always #5 clk = ~clk;

  // Binary-search upper bound over the entries held: first index whose entry
  // exceeds the key, or the count when none does.
  function automatic int shadow_upper_bound(input logic [31:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key >= shadow_entries[mid]) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one accepted request to the shadow table and work out its result.
  task automatic predict_table_op(input op_req_t rq, output op_result_t r);
    int idx;
    int i;
    int ub;
    r = '0;
    case (rq.opcode)
      OP_INSERT: begin
        if (rq.run_length != 0) begin
          if (shadow_count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // Clamp past-the-end inserts to an append.
            idx = (int'(rq.slot) < shadow_count) ? int'(rq.slot) : shadow_count;
            for (i = shadow_count; i > idx; i--) shadow_entries[i] = shadow_entries[i - 1];
            shadow_entries[idx] = rq.value;
            shadow_count++;
            r.position = 7'(idx);
          end
        end
      end
      OP_REMOVE: begin
        if (rq.run_length != 0) begin
          if (int'(rq.slot) >= shadow_count ||
              int'(rq.slot) + int'(rq.run_length) > shadow_count) begin
            r.status = ST_RANGE;
          end else begin
            // Close the gap left by the removed run.
            for (i = int'(rq.slot); i + int'(rq.run_length) < shadow_count; i++)
              shadow_entries[i] = shadow_entries[i + int'(rq.run_length)];
            shadow_count -= int'(rq.run_length);
            r.position = 7'(rq.slot);
          end
        end
      end
      OP_READ: begin
        if (int'(rq.slot) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = shadow_entries[rq.slot];
          r.position   = 7'(rq.slot);
        end
      end
      OP_FIND: begin
        r.position = 7'(shadow_count);
        if (shadow_sorted) begin
          // Only the entry just below the upper bound can match.
          ub = shadow_upper_bound(rq.value);
          if (ub > 0 && shadow_entries[ub - 1] == rq.value) begin
            r.found    = 1'b1;
            r.position = 7'(ub - 1);
          end
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            if (shadow_entries[i] == rq.value) begin
              r.found    = 1'b1;
              r.position = 7'(i);
              break;
            end
          end
        end
      end
      OP_POSITION: begin
        r.position = shadow_sorted ? 7'(shadow_upper_bound(rq.value)) : 7'(shadow_count);
      end
      default: begin
        // Unused opcodes leave the table alone.
      end
    endcase
    r.occupancy = 7'(shadow_count);
  endtask

  // Keys: bias towards the extremes and a small pool so duplicates turn up.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000 | $urandom_range(3);
      3, 4:    return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests shaped by the current table; a little noise
  // with every field anywhere in its width.
  function automatic op_req_t random_request();
    op_req_t rq;
    int      pick;
    int      n;
    int      span;
    n    = shadow_count;
    pick = $urandom_range(99);
    rq.opcode     = OP_READ;
    rq.slot       = '0;
    rq.run_length = '0;
    rq.value      = pick_value();
    if (pick < 4) begin
      rq.opcode     = 3'($urandom);
      rq.slot       = 8'($urandom);
      rq.run_length = 7'($urandom);
      rq.value      = $urandom;
    end else if (pick < 40) begin
      rq.opcode     = OP_INSERT;
      rq.run_length = ($urandom_range(19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
      if (shadow_sorted) rq.slot = 8'(shadow_upper_bound(rq.value));
      else rq.slot = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(0, n));
    end else if (pick < 56) begin
      rq.opcode = OP_REMOVE;
      if (n == 0 || $urandom_range(7) == 0) begin
        rq.slot       = 8'($urandom_range(0, n + 2));
        rq.run_length = 7'($urandom_range(0, 127));
      end else begin
        rq.slot = 8'($urandom_range(0, n - 1));
        span    = n - int'(rq.slot);
        if ($urandom_range(7) == 0) rq.run_length = 7'(span);
        else rq.run_length = 7'($urandom_range(1, (span < 3) ? span : 3));
      end
    end else if (pick < 78) begin
      rq.opcode = OP_FIND;
      if (n > 0 && $urandom_range(2) != 0) rq.value = shadow_entries[$urandom_range(0, n - 1)];
    end else if (pick < 90) begin
      rq.opcode = OP_POSITION;
      if (n > 0 && $urandom_range(1) != 0) rq.value = shadow_entries[$urandom_range(0, n - 1)];
    end else begin
      rq.slot = ($urandom_range(9) == 0) ? 8'($urandom_range(n, 255)) : 8'($urandom_range(0, n));
    end
    return rq;
  endfunction

  function automatic step_row_t step_row(
    input logic        sorted,
    input logic [2:0]  op,
    input logic [7:0]  slot,
    input logic [6:0]  run,
    input logic [31:0] value,
    input bit          typed,
    input logic [1:0]  status,
    input logic        found,
    input logic [6:0]  position,
    input logic [31:0] read_value,
    input logic [6:0]  occupancy
  );
    step_row_t rw;
    rw.sorted = sorted;
    rw.req    = '{opcode: op, slot: slot, run_length: run, value: value};
    rw.typed  = typed;
    rw.want   = '{status: status, found: found, position: position,
                  read_value: read_value, occupancy: occupancy};
    return rw;
  endfunction

  // Present one request from the next falling edge and hold it until taken,
  // with a random gap ahead of it unless idling is switched off.
  task automatic send_request(input op_req_t rq, input bit typed, input op_result_t typed_want);
    op_result_t want;
    int         gap;
    if (!no_idling && $urandom_range(99) < 18) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= rq.opcode;
    in_slot       <= rq.slot;
    in_run_length <= rq.run_length;
    in_value      <= rq.value;
    do @(posedge clk); while (in_stall);
    predict_table_op(rq, want);
    pending_results.push_back(typed ? typed_want : want);
    requests_sent++;
    if (shadow_sorted) sorted_requests++;
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Change the search mode only once the block has gone idle.
  task automatic write_mode(input logic sorted);
    drain_requests();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_sorted_mode <= sorted;
    do @(posedge clk); while (!cfg_ready);
    shadow_sorted = sorted;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: stall at random and check every result taken against the
  // oldest expectation.
  always @(negedge clk) out_stall <= !no_idling && ($urandom_range(99) < 18);

  always @(posedge clk) begin : result_check
    op_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_status == ST_FULL) full_seen++;
      if (out_status == ST_RANGE) range_seen++;
      if (pending_results.size() == 0) begin
        $error("result taken with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("found", 32'(want.found), 32'(out_found));
        check_field("position", 32'(want.position), 32'(out_position));
        check_field("read_value", want.read_value, out_read_value);
        check_field("occupancy", 32'(want.occupancy), 32'(out_occupancy));
      end
    end
  end

  // Watchdog: end the run if no handshake of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL ordered_table_with_search");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    op_req_t   rq;
    step_row_t rw;
    int        phase;
    int        k;

    // Initialise every input before the first edge.
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_READ;
    in_slot         = '0;
    in_run_length   = '0;
    in_value        = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_sorted_mode = 1'b0;
    no_idling       = 1'b0;
    mismatches      = 0;
    requests_sent   = 0;
    sorted_requests = 0;
    results_seen    = 0;
    full_seen       = 0;
    range_seen      = 0;
    stuck_cycles    = 0;
    shadow_count    = 0;
    shadow_sorted   = 1'b0;

    // Directed requests in plain mode, starting from the empty table.
    directed_rows.push_back(step_row(0, OP_READ, 8'd0, 7'd0, 32'h0,
                                     1, ST_RANGE, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(0, OP_REMOVE, 8'd0, 7'd1, 32'h0,
                                     1, ST_RANGE, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(0, OP_FIND, 8'd0, 7'd0, 32'h0,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(0, OP_POSITION, 8'd0, 7'd0, 32'hFFFF_FFFF,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    // Zero-length insert does nothing.
    directed_rows.push_back(step_row(0, OP_INSERT, 8'd0, 7'd0, 32'h5,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    // Insert past the end is appended.
    directed_rows.push_back(step_row(0, OP_INSERT, 8'd255, 7'd1, 32'hFFFF_FFFF,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd1));
    directed_rows.push_back(step_row(0, OP_INSERT, 8'd0, 7'd127, 32'h0,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd2));
    directed_rows.push_back(step_row(0, OP_INSERT, 8'd1, 7'd64, 32'h8000_0000,
                                     1, ST_OK, 0, 7'd1, 32'h0, 7'd3));
    directed_rows.push_back(step_row(0, OP_READ, 8'd255, 7'd0, 32'h0,
                                     1, ST_RANGE, 0, 7'd0, 32'h0, 7'd3));
    directed_rows.push_back(step_row(0, OP_READ, 8'd2, 7'd0, 32'h0,
                                     1, ST_OK, 0, 7'd2, 32'hFFFF_FFFF, 7'd3));
    directed_rows.push_back(step_row(0, OP_FIND, 8'd0, 7'd0, 32'h8000_0000,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(0, OP_FIND, 8'd0, 7'd0, 32'h1234_5678,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(0, OP_POSITION, 8'd0, 7'd0, 32'h0,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    // Unused opcode is ignored whatever the other fields hold.
    directed_rows.push_back(step_row(0, 3'd7, 8'd255, 7'd127, 32'hFFFF_FFFF,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd3));
    directed_rows.push_back(step_row(0, OP_REMOVE, 8'd1, 7'd0, 32'h0,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd3));
    // Run reaching past the count, then slot at the count.
    directed_rows.push_back(step_row(0, OP_REMOVE, 8'd1, 7'd127, 32'h0,
                                     1, ST_RANGE, 0, 7'd0, 32'h0, 7'd3));
    directed_rows.push_back(step_row(0, OP_REMOVE, 8'd3, 7'd1, 32'h0,
                                     1, ST_RANGE, 0, 7'd0, 32'h0, 7'd3));
    // Removing the tail is allowed.
    directed_rows.push_back(step_row(0, OP_REMOVE, 8'd2, 7'd1, 32'h0,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(0, OP_REMOVE, 8'd0, 7'd2, 32'h0,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    // Sorted mode with a duplicate: find must land on the last copy.
    directed_rows.push_back(step_row(1, OP_INSERT, 8'd0, 7'd1, 32'h7,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(1, OP_INSERT, 8'd1, 7'd1, 32'h7,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(1, OP_INSERT, 8'd255, 7'd1, 32'hFFFF_FFFF,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(1, OP_FIND, 8'd0, 7'd0, 32'h7,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(1, OP_POSITION, 8'd0, 7'd0, 32'h7,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(1, OP_FIND, 8'd0, 7'd0, 32'h0,
                                     0, ST_OK, 0, 7'd0, 32'h0, 7'd0));
    directed_rows.push_back(step_row(1, OP_REMOVE, 8'd0, 7'd3, 32'h0,
                                     1, ST_OK, 0, 7'd0, 32'h0, 7'd0));

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      rw = directed_rows[r];
      if (rw.sorted != shadow_sorted) write_mode(rw.sorted);
      send_request(rw.req, rw.typed, rw.want);
    end

    // Random phases, alternating the mode; the third runs with no idling.
    for (phase = 0; phase < 4; phase++) begin
      write_mode(PHASE_MODES[phase]);
      no_idling = (phase == 2);
      if (shadow_sorted) begin
        // Clear the table so binary search starts on sorted contents.
        if (shadow_count > 0) begin
          rq = '{opcode: OP_REMOVE, slot: 8'd0, run_length: 7'(shadow_count), value: 32'h0};
          send_request(rq, 1'b0, '0);
        end
        // First sorted phase: fill to the top and push two more into the full table.
        if (phase == 0) begin
          while (shadow_count < DEPTH + 2) begin
            rq.opcode     = OP_INSERT;
            rq.run_length = 7'd1;
            rq.value      = pick_value();
            rq.slot       = 8'(shadow_upper_bound(rq.value));
            send_request(rq, 1'b0, '0);
            if (shadow_count == DEPTH) begin
              send_request(rq, 1'b0, '0);
              send_request(rq, 1'b0, '0);
              break;
            end
          end
        end
      end
      for (k = 0; k < PHASE_REQUESTS; k++) send_request(random_request(), 1'b0, '0);
    end
    no_idling = 1'b0;

    // Let the pipeline settle so any stray result is caught.
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d in sorted mode) and checked %0d results.",
             requests_sent, sorted_requests, results_seen);
    $display("Rejections seen: %0d table full, %0d index out of range; %0d mismatches.",
             full_seen, range_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS ordered_table_with_search");
    end else begin
      $display("FAIL ordered_table_with_search");
    end
    $finish;
  end

endmodule
